@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL. Each macro expands to a labelled
// concurrent assertion in simulation and to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every rising edge of clk, switched off while rst is high.
`define ASSERT_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Checked on every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_RST(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ rtl/hmp_pkg.sv @@
package hmp_pkg;

  localparam logic MODE_MD5    = 1'b0;
  localparam logic MODE_SHA256 = 1'b1;

  localparam logic [7:0] PAD_MARK = 8'h80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] block_word;
    logic [3:0]  word_index;
    logic        message_end;
    logic        run_end;
  } out_item_t;

  // Progress of the padding sequence for one message.
  typedef struct packed {
    logic       first;   // next word holds the 0x80 mark
    logic       extra;   // the length goes into the following block
    logic [3:0] widx;    // index of the next word in its block
    logic [1:0] mpos;    // byte position of the 0x80 mark in the first word
  } pad_ctl_t;

  // Turns a word whose first byte sits in bits 31..24 into the word the
  // selected hash expects.
  function automatic logic [31:0] order_word(logic mode, logic [31:0] w);
    logic [31:0] r;
    if (mode == MODE_SHA256) begin
      r = w;
    end else begin
      r = {w[7:0], w[15:8], w[23:16], w[31:24]};
    end
    return r;
  endfunction

endpackage

@@ rtl/hmp_pad_word.sv @@
module hmp_pad_word
  import hmp_pkg::*;
(
  input  logic        mode,
  input  pad_ctl_t    ctl,
  input  logic [23:0] accum,
  input  logic [63:0] bit_len,
  output logic [31:0] word,
  output logic        last_word
);

  logic [31:0] mark_word;
  logic        in_len;

  // Held bytes come first, newest in the low bits of accum.
  always_comb begin
    case (ctl.mpos)
      2'd0:    mark_word = {PAD_MARK, 24'h0};
      2'd1:    mark_word = {accum[7:0], PAD_MARK, 16'h0};
      2'd2:    mark_word = {accum[15:8], accum[7:0], PAD_MARK, 8'h0};
      default: mark_word = {accum[23:16], accum[15:8], accum[7:0], PAD_MARK};
    endcase
  end

  assign in_len    = !ctl.extra && (ctl.widx[3:1] == 3'b111);
  assign last_word = !ctl.extra && (ctl.widx == 4'hf);

  // The length words need no reordering: each mode simply takes the
  // halves of the bit count in its own order.
  always_comb begin
    if (ctl.first) begin
      word = order_word(mode, mark_word);
    end else if (in_len) begin
      if ((mode == MODE_SHA256) == (ctl.widx[0] == 1'b0)) begin
        word = bit_len[63:32];
      end else begin
        word = bit_len[31:0];
      end
    end else begin
      word = 32'h0;
    end
  end

endmodule

@@ rtl/hash_message_padder.sv @@
// Message padding front end for MD5 and SHA-256.
// The input channel (in_valid, in_stall, in_item) carries one message byte
// per transfer, with has_byte and is_last flags. The output channel
// (out_valid, out_stall, out_item) carries one 32-bit block word per
// transfer with its index in the 64-byte block, message_end on the final
// word of the padded message, and run_end on the last word caused by one
// input transfer. The cfg channel writes the mode bit: 0 selects MD5
// (little-endian), 1 selects SHA-256 (big-endian). cfg_ready is always high.
// Throughput is one byte per cycle while in_stall is low. A word appears in
// the output register the cycle after the transfer of its fourth byte. On an
// is_last transfer the padding words follow, one per cycle while the receiver
// does not stall; there are 16 - (n mod 64)/4 of them, or 16 more when
// n mod 64 is 56 or above (n = message length in bytes). in_stall is held
// high while padding runs.
// When the receiver stalls, the output register holds its word and in_stall
// rises in the same cycle, so nothing is lost. A synchronous reset empties
// the output register, abandons any message in progress and selects MD5.
`include "assert_macros.svh"

module hash_message_padder
  import hmp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  // Message state: bytes taken so far and the bytes of the unfinished word.
  logic [60:0] byte_count;
  logic [60:0] byte_count_next;
  logic [23:0] accum;
  logic [23:0] accum_next;
  logic        mode;

  // Padding state. While pad is set the block emits padding words and
  // takes no input; byte_count then holds the message length.
  logic        pad;
  pad_ctl_t    ctl;

  logic        out_free;
  logic        in_fire;
  logic [1:0]  pos;
  logic        word_done;
  logic [31:0] data_word;
  logic [31:0] pad_word;
  logic        pad_last;
  logic        pad_fire;

  // The output register can load when it is empty or its word is leaving.
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = pad || !out_free;
  assign in_fire   = in_valid && !in_stall;
  assign pad_fire  = pad && out_free;
  assign cfg_ready = 1'b1;

  assign pos       = byte_count[1:0];
  assign word_done = in_item.has_byte && (pos == 2'd3);
  assign data_word = order_word(mode, {accum, in_item.data_byte});

  always_comb begin
    byte_count_next = byte_count;
    accum_next      = accum;
    if (in_item.has_byte) begin
      byte_count_next = byte_count + 61'd1;
      if (pos == 2'd3) begin
        accum_next = 24'h0;
      end else begin
        accum_next = {accum[15:0], in_item.data_byte};
      end
    end
  end

  hmp_pad_word u_pad_word (
    .mode      (mode),
    .ctl       (ctl),
    .accum     (accum),
    .bit_len   ({byte_count, 3'b000}),
    .word      (pad_word),
    .last_word (pad_last)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_MD5;
    end else if (cfg_valid && cfg_ready) begin
      mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= 61'd0;
      accum      <= 24'h0;
      pad        <= 1'b0;
      ctl        <= '0;
    end else if (in_fire) begin
      byte_count <= byte_count_next;
      accum      <= accum_next;
      if (in_item.is_last) begin
        // The mark lands at byte n mod 64; from byte 56 on the length
        // does not fit and a further block follows.
        pad        <= 1'b1;
        ctl.first  <= 1'b1;
        ctl.extra  <= (byte_count_next[5:3] == 3'b111);
        ctl.widx   <= byte_count_next[5:2];
        ctl.mpos   <= byte_count_next[1:0];
      end
    end else if (pad_fire) begin
      ctl.first <= 1'b0;
      ctl.widx  <= ctl.widx + 4'd1;
      if (ctl.widx == 4'hf) begin
        ctl.extra <= 1'b0;
      end
      if (pad_last) begin
        pad        <= 1'b0;
        byte_count <= 61'd0;
        accum      <= 24'h0;
      end
    end
  end

  // Output register: a completed data word or the next padding word.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= (in_fire && word_done) || pad_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (pad) begin
        out_item.block_word  <= pad_word;
        out_item.word_index  <= ctl.widx;
        out_item.message_end <= pad_last;
        out_item.run_end     <= pad_last;
      end else begin
        out_item.block_word  <= data_word;
        out_item.word_index  <= byte_count[5:2];
        out_item.message_end <= 1'b0;
        out_item.run_end     <= !in_item.is_last;
      end
    end
  end

  // The final word always closes the run and sits at the end of a block.
  `ASSERT_ALWAYS(a_end_closes_run, clk,
    (out_valid && out_item.message_end) |-> out_item.run_end)
  `ASSERT_RST(a_end_index, clk, rst,
    (out_valid && out_item.message_end) |-> (out_item.word_index == 4'hf))
  // Once the final padding word is taken, a fresh message starts.
  `ASSERT_RST(a_pad_done, clk, rst,
    (pad_fire && pad_last) |=> (!pad && (byte_count == 61'd0) && (accum == 24'h0)))
  // The mark word is always the first word of the padding.
  `ASSERT_RST(a_mark_first, clk, rst,
    (pad_fire && ctl.first) |=> (!ctl.first))

endmodule
